### rtl/core/mstp_pkg.sv
package mstp_pkg;

  localparam int CUR_W   = 12;
  localparam int HEAT_W  = 40;
  localparam int DELTA_W = 16;
  localparam int PWM_W   = 7;
  localparam int MIN_W   = 15;
  localparam int TICK_W  = 10;
  localparam int COOL_W  = 24;
  localparam int IDX_W   = 8;
  localparam int STATE_W = 2;

  // shared multiplier: 24 x 12 covers cur*cur, (cur^2)*tick and cooling*tick
  localparam int MUL_A_W = 24;
  localparam int MUL_B_W = 12;
  localparam int PROD_W  = MUL_A_W + MUL_B_W;
  // shared add/subtract unit: room for 2*heat plus a borrow bit
  localparam int ALU_W   = HEAT_W + 2;

  localparam logic [PWM_W-1:0]  PWM_MAX  = 7'd100;
  localparam logic [HEAT_W-1:0] HEAT_MAX = {HEAT_W{1'b1}};

  localparam logic [CUR_W-1:0]  RST_STALL_CURRENT   = 12'd1536;
  localparam logic [CUR_W-1:0]  RST_WARNING_CURRENT = 12'd1075;
  localparam logic [HEAT_W-1:0] RST_THERMAL_LIMIT   = 40'd3276800000;
  localparam logic [MIN_W-1:0]  RST_MIN_TICK_DELTA  = 15'd5;
  localparam logic [PWM_W-1:0]  RST_STALL_PWM_LEVEL = 7'd40;
  localparam logic [PWM_W-1:0]  RST_LIMP_PWM_LIMIT  = 7'd20;
  localparam logic [TICK_W-1:0] RST_TICK_INTERVAL   = 10'd500;
  localparam logic [COOL_W-1:0] RST_COOLING_PER_MS  = 24'd655360;

  typedef enum logic [IDX_W-1:0] {
    REG_STALL_CURRENT    = 8'd0,
    REG_WARNING_CURRENT  = 8'd1,
    REG_THERMAL_LIMIT    = 8'd2,
    REG_MIN_TICK_DELTA   = 8'd3,
    REG_STALL_PWM_LEVEL  = 8'd4,
    REG_LIMP_PWM_LIMIT   = 8'd5,
    REG_TICK_INTERVAL_MS = 8'd6,
    REG_COOLING_PER_MS   = 8'd7
  } reg_idx_t;

  typedef enum logic [STATE_W-1:0] {
    PS_NORMAL   = 2'd0,
    PS_WARNING  = 2'd1,
    PS_LIMP     = 2'd2,
    PS_SHUTDOWN = 2'd3
  } protect_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_MUL1,
    S_MUL2,
    S_ACC,
    S_CMP1,
    S_CMP2
  } seq_t;

endpackage

### rtl/core/mstp_ifs.sv
interface mstp_sample_if;
  import mstp_pkg::*;

  logic                      valid;
  logic                      ready;
  logic        [CUR_W-1:0]   motor_current;
  logic signed [DELTA_W-1:0] encoder_delta;
  logic        [PWM_W-1:0]   duty_cmd;

  modport source (output valid, motor_current, encoder_delta, duty_cmd, input ready);
  modport sink   (input valid, motor_current, encoder_delta, duty_cmd, output ready);
endinterface

interface mstp_result_if;
  import mstp_pkg::*;

  logic                valid;
  logic                ready;
  logic [PWM_W-1:0]    duty_out;
  logic [STATE_W-1:0]  protect_state;
  logic [HEAT_W-1:0]   thermal_load;

  modport source (output valid, duty_out, protect_state, thermal_load, input ready);
  modport sink   (input valid, duty_out, protect_state, thermal_load, output ready);
endinterface

interface mstp_cfg_if;
  import mstp_pkg::*;

  logic              valid;
  logic              ready;
  logic [IDX_W-1:0]  index;
  logic [HEAT_W-1:0] data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

### rtl/core/motor_stall_i2t_protector.sv
// Motor stall and I^2t overcurrent protector. Each sample item (current in 1/256 A, signed
// encoder delta, commanded PWM percent) updates a 40-bit heat accumulator and yields one
// result item: the permitted PWM, a protection state (normal, heating warning, limp,
// shutdown) and the new accumulator value. Shutdown holds until reset. After acceptance an
// item passes through five steps of a small sequencer, which share one 24x12 multiplier
// and one 42-bit add/subtract unit (two products, accumulator update, two limit compares),
// before the block is ready again. The result sits in an output register, so the next item
// is taken while it waits, but a new result is not loaded before the previous one has been
// taken. Configuration writes are always accepted; unknown register indexes are dropped.
module motor_stall_i2t_protector (
  input logic         clk,
  input logic         rst,
  mstp_sample_if.sink sample,
  mstp_result_if.source result,
  mstp_cfg_if.sink    cfg
);
  import mstp_pkg::*;

  // configuration registers
  logic [CUR_W-1:0]  stall_current;
  logic [CUR_W-1:0]  warning_current;
  logic [HEAT_W-1:0] thermal_limit;
  logic [MIN_W-1:0]  min_tick_delta;
  logic [PWM_W-1:0]  stall_pwm_level;
  logic [PWM_W-1:0]  limp_pwm_limit;
  logic [TICK_W-1:0] tick_interval_ms;
  logic [COOL_W-1:0] cooling_per_ms;

  // state
  seq_t              state, state_next;
  logic [HEAT_W-1:0] heat_accumulator;
  logic              shutdown_latched;

  // captured item
  logic [CUR_W-1:0]  cur;
  logic [PWM_W-1:0]  pwm;
  logic              hot;
  logic              stalled;
  logic              warn;
  logic              shut_hit;
  logic [PROD_W-1:0] prod;

  // shared units
  logic [MUL_A_W-1:0] mul_a;
  logic [MUL_B_W-1:0] mul_b;
  logic [PROD_W-1:0]  mul_p;
  logic [ALU_W-1:0]   alu_a, alu_b, alu_r;
  logic               alu_sub;

  logic [PWM_W-1:0]   pwm_in_sat;
  logic               take_item;
  logic               out_free;
  logic               limp_hit;
  logic [PWM_W-1:0]   limp_pwm;

  assign sample.ready = (state == S_IDLE);
  assign cfg.ready    = 1'b1;
  assign take_item    = sample.valid && sample.ready;
  assign out_free     = !result.valid || result.ready;

  assign pwm_in_sat = (sample.duty_cmd > PWM_MAX) ? PWM_MAX : sample.duty_cmd;

  assign mul_p = PROD_W'(mul_a) * PROD_W'(mul_b);
  assign alu_r = alu_sub ? (alu_a - alu_b) : (alu_a + alu_b);

  // borrow on limit - 2*heat means heat is above half the limit
  assign limp_hit = alu_r[ALU_W-1];
  assign limp_pwm = (pwm < limp_pwm_limit) ? pwm : limp_pwm_limit;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    mul_a      = '0;
    mul_b      = '0;
    alu_a      = '0;
    alu_b      = '0;
    alu_sub    = 1'b0;
    unique case (state)
      S_IDLE: begin
        if (take_item) begin
          state_next = S_MUL1;
        end
      end
      S_MUL1: begin
        if (hot) begin
          mul_a = MUL_A_W'(cur);
          mul_b = MUL_B_W'(cur);
        end else begin
          mul_a = MUL_A_W'(cooling_per_ms);
          mul_b = MUL_B_W'(tick_interval_ms);
        end
        state_next = S_MUL2;
      end
      S_MUL2: begin
        mul_a      = prod[MUL_A_W-1:0];
        mul_b      = MUL_B_W'(tick_interval_ms);
        state_next = S_ACC;
      end
      S_ACC: begin
        alu_a      = ALU_W'(heat_accumulator);
        alu_b      = ALU_W'(prod);
        alu_sub    = !hot;
        state_next = S_CMP1;
      end
      S_CMP1: begin
        alu_a      = ALU_W'(heat_accumulator);
        alu_b      = ALU_W'(thermal_limit);
        alu_sub    = 1'b1;
        state_next = S_CMP2;
      end
      S_CMP2: begin
        alu_a   = ALU_W'(thermal_limit);
        alu_b   = ALU_W'({heat_accumulator, 1'b0});
        alu_sub = 1'b1;
        if (out_free) begin
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  // configuration
  always_ff @(posedge clk) begin
    if (rst) begin
      stall_current    <= RST_STALL_CURRENT;
      warning_current  <= RST_WARNING_CURRENT;
      thermal_limit    <= RST_THERMAL_LIMIT;
      min_tick_delta   <= RST_MIN_TICK_DELTA;
      stall_pwm_level  <= RST_STALL_PWM_LEVEL;
      limp_pwm_limit   <= RST_LIMP_PWM_LIMIT;
      tick_interval_ms <= RST_TICK_INTERVAL;
      cooling_per_ms   <= RST_COOLING_PER_MS;
    end else if (cfg.valid && cfg.ready) begin
      case (cfg.index)
        REG_STALL_CURRENT:    stall_current    <= cfg.data[CUR_W-1:0];
        REG_WARNING_CURRENT:  warning_current  <= cfg.data[CUR_W-1:0];
        REG_THERMAL_LIMIT:    thermal_limit    <= cfg.data[HEAT_W-1:0];
        REG_MIN_TICK_DELTA:   min_tick_delta   <= cfg.data[MIN_W-1:0];
        REG_STALL_PWM_LEVEL:  stall_pwm_level  <= cfg.data[PWM_W-1:0];
        REG_LIMP_PWM_LIMIT:   limp_pwm_limit   <= cfg.data[PWM_W-1:0];
        REG_TICK_INTERVAL_MS: tick_interval_ms <= cfg.data[TICK_W-1:0];
        REG_COOLING_PER_MS:   cooling_per_ms   <= cfg.data[COOL_W-1:0];
        default: ;
      endcase
    end
  end

  // item capture and datapath
  always_ff @(posedge clk) begin
    if (take_item) begin
      cur     <= sample.motor_current;
      pwm     <= pwm_in_sat;
      hot     <= sample.motor_current > stall_current;
      warn    <= sample.motor_current > warning_current;
      stalled <= (pwm_in_sat >= stall_pwm_level) &&
                 (sample.motor_current >= stall_current) &&
                 (sample.encoder_delta < $signed({1'b0, min_tick_delta}));
    end
    if (state == S_MUL1 || (state == S_MUL2 && hot)) begin
      prod <= mul_p;
    end
    if (state == S_CMP1) begin
      shut_hit <= !alu_r[ALU_W-1];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      heat_accumulator <= '0;
      shutdown_latched <= 1'b0;
    end else begin
      if (state == S_ACC) begin
        if (hot) begin
          heat_accumulator <= alu_r[HEAT_W] ? HEAT_MAX : alu_r[HEAT_W-1:0];
        end else begin
          // borrow means the cooling took it below zero
          heat_accumulator <= alu_r[ALU_W-1] ? '0 : alu_r[HEAT_W-1:0];
        end
      end
      if (state == S_CMP2 && out_free && shut_hit) begin
        shutdown_latched <= 1'b1;
      end
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      result.valid <= 1'b0;
    end else if (state == S_CMP2 && out_free) begin
      result.valid <= 1'b1;
    end else if (result.ready) begin
      result.valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state == S_CMP2 && out_free) begin
      result.thermal_load <= heat_accumulator;
      if (shutdown_latched || shut_hit) begin
        result.duty_out      <= '0;
        result.protect_state <= PS_SHUTDOWN;
      end else if (stalled || limp_hit) begin
        result.duty_out      <= limp_pwm;
        result.protect_state <= PS_LIMP;
      end else if (warn) begin
        result.duty_out      <= pwm;
        result.protect_state <= PS_WARNING;
      end else begin
        result.duty_out      <= pwm;
        result.protect_state <= PS_NORMAL;
      end
    end
  end

  a_shutdown_holds: assert property (@(posedge clk) disable iff (rst)
    shutdown_latched |=> shutdown_latched)
    else $error("shutdown latch released without reset");

  a_shutdown_zero_pwm: assert property (@(posedge clk) disable iff (rst)
    result.valid && result.protect_state == PS_SHUTDOWN |-> result.duty_out == '0)
    else $error("nonzero pwm in shutdown");

  a_pwm_in_range: assert property (@(posedge clk) disable iff (rst)
    result.valid |-> result.duty_out <= PWM_MAX)
    else $error("output duty above full duty");

  a_result_from_seq: assert property (@(posedge clk) disable iff (rst)
    $rose(result.valid) |-> $past(state) == S_CMP2)
    else $error("result loaded outside the final step");

endmodule

### dv/tb_motor_stall_i2t_protector.sv
`timescale 1ns / 1ps

module tb_motor_stall_i2t_protector;
  import mstp_pkg::*;

  localparam int GAIN_W  = 2 * CUR_W + TICK_W;
  localparam int COOLP_W = COOL_W + TICK_W;

  typedef struct packed {
    logic [PWM_W-1:0]  duty_out;
    protect_t          protect_state;
    logic [HEAT_W-1:0] thermal_load;
  } i2t_result_t;

  class i2t_scoreboard;
    logic [CUR_W-1:0]  stall_cur;
    logic [CUR_W-1:0]  warn_cur;
    logic [HEAT_W-1:0] limit;
    logic [MIN_W-1:0]  min_delta;
    logic [PWM_W-1:0]  stall_pwm;
    logic [PWM_W-1:0]  limp_pwm;
    logic [TICK_W-1:0] tick_ms;
    logic [COOL_W-1:0] cool_ms;
    logic [HEAT_W-1:0] heat;
    bit                tripped;
    i2t_result_t       expected_results[$];
    int unsigned       errors;

    function new();
      stall_cur = RST_STALL_CURRENT;
      warn_cur  = RST_WARNING_CURRENT;
      limit     = RST_THERMAL_LIMIT;
      min_delta = RST_MIN_TICK_DELTA;
      stall_pwm = RST_STALL_PWM_LEVEL;
      limp_pwm  = RST_LIMP_PWM_LIMIT;
      tick_ms   = RST_TICK_INTERVAL;
      cool_ms   = RST_COOLING_PER_MS;
      heat      = '0;
      tripped   = 1'b0;
      errors    = 0;
    endfunction

    function void write_reg(logic [IDX_W-1:0] idx, logic [HEAT_W-1:0] val);
      case (idx)
        REG_STALL_CURRENT:    stall_cur = val[CUR_W-1:0];
        REG_WARNING_CURRENT:  warn_cur  = val[CUR_W-1:0];
        REG_THERMAL_LIMIT:    limit     = val;
        REG_MIN_TICK_DELTA:   min_delta = val[MIN_W-1:0];
        REG_STALL_PWM_LEVEL:  stall_pwm = val[PWM_W-1:0];
        REG_LIMP_PWM_LIMIT:   limp_pwm  = val[PWM_W-1:0];
        REG_TICK_INTERVAL_MS: tick_ms   = val[TICK_W-1:0];
        REG_COOLING_PER_MS:   cool_ms   = val[COOL_W-1:0];
        default: ;
      endcase
    endfunction

    function void note_sample(logic [CUR_W-1:0] cur, logic signed [DELTA_W-1:0] delta,
                              logic [PWM_W-1:0] pwm);
      logic [PWM_W-1:0]              duty;
      logic [GAIN_W-1:0]             gain;
      logic [COOLP_W-1:0]            cool;
      logic [HEAT_W:0]               sum;
      bit                            stalled;
      i2t_result_t                   want;
      duty = (pwm > PWM_MAX) ? PWM_MAX : pwm;
      if (cur > stall_cur) begin
        gain = GAIN_W'(cur) * GAIN_W'(cur) * GAIN_W'(tick_ms);
        sum  = {1'b0, heat} + (HEAT_W+1)'(gain);
        heat = sum[HEAT_W] ? HEAT_MAX : sum[HEAT_W-1:0];
      end else begin
        cool = COOLP_W'(cool_ms) * COOLP_W'(tick_ms);
        heat = (heat > HEAT_W'(cool)) ? heat - HEAT_W'(cool) : '0;
      end
      stalled = (duty >= stall_pwm) && (cur >= stall_cur) &&
                ($signed(delta) < $signed({1'b0, min_delta}));
      want.thermal_load = heat;
      if (tripped || heat >= limit) begin
        tripped = 1'b1;
        want.duty_out = '0;
        want.protect_state = PS_SHUTDOWN;
      end else if (stalled || ({heat, 1'b0} > {1'b0, limit})) begin
        want.duty_out = (duty < limp_pwm) ? duty : limp_pwm;
        want.protect_state = PS_LIMP;
      end else if (cur > warn_cur) begin
        want.duty_out = duty;
        want.protect_state = PS_WARNING;
      end else begin
        want.duty_out = duty;
        want.protect_state = PS_NORMAL;
      end
      expected_results.push_back(want);
    endfunction

    function void check_result(logic [PWM_W-1:0] safe, logic [STATE_W-1:0] st,
                               logic [HEAT_W-1:0] load);
      i2t_result_t want;
      if (expected_results.size() == 0) begin
        $error("result item with no sample pending: duty_out %0d protect_state %0d",
               safe, st);
        errors++;
        return;
      end
      want = expected_results.pop_front();
      if (safe !== want.duty_out) begin
        $error("duty_out: expected %0d, got %0d", want.duty_out, safe);
        errors++;
      end
      if (st !== want.protect_state) begin
        $error("protect_state: expected %0d, got %0d", want.protect_state, st);
        errors++;
      end
      if (load !== want.thermal_load) begin
        $error("thermal_load: expected %0d, got %0d", want.thermal_load, load);
        errors++;
      end
    endfunction

    function int unsigned pending();
      return expected_results.size();
    endfunction
  endclass

  logic clk;
  logic rst;
  bit   idle_on;
  bit   hold_req;

  i2t_scoreboard sb = new();

  mstp_sample_if sample_ch ();
  mstp_result_if result_ch ();
  mstp_cfg_if    cfg_ch ();

  motor_stall_i2t_protector dut (
    .clk    (clk),
    .rst    (rst),
    .sample (sample_ch),
    .result (result_ch),
    .cfg    (cfg_ch)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  initial begin
    #5_000_000;
    $display("CHECKS FAILED");
    $finish;
  end

  // result side: random back-pressure bursts, plus one long hold-off on request
  initial begin
    int unsigned stall_left;
    stall_left = 0;
    result_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_req) begin
        stall_left = 300;
        hold_req = 1'b0;
      end else if (stall_left == 0 && idle_on && $urandom_range(0, 5) == 0) begin
        stall_left = $urandom_range(1, 8);
      end
      if (stall_left > 0) begin
        result_ch.ready <= 1'b0;
        stall_left--;
      end else begin
        result_ch.ready <= 1'b1;
      end
    end
  end

  always @(posedge clk) begin
    if (!rst && result_ch.valid && result_ch.ready)
      sb.check_result(result_ch.duty_out, result_ch.protect_state, result_ch.thermal_load);
  end

  task automatic write_cfg(input logic [IDX_W-1:0] idx, input logic [HEAT_W-1:0] val);
    cfg_ch.valid <= 1'b1;
    cfg_ch.index <= idx;
    cfg_ch.data  <= val;
    do @(posedge clk); while (!cfg_ch.ready);
    sb.write_reg(idx, val);
    cfg_ch.valid <= 1'b0;
    @(posedge clk);
  endtask

  task automatic send_sample(input logic [CUR_W-1:0] cur, input logic signed [DELTA_W-1:0] delta,
                             input logic [PWM_W-1:0] pwm);
    sample_ch.valid         <= 1'b1;
    sample_ch.motor_current <= cur;
    sample_ch.encoder_delta <= delta;
    sample_ch.duty_cmd      <= pwm;
    do @(posedge clk); while (!sample_ch.ready);
    sb.note_sample(cur, delta, pwm);
    if (idle_on && $urandom_range(0, 5) == 0) begin
      sample_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 8)) @(posedge clk);
    end
  endtask

  task automatic wait_drained();
    if (sample_ch.valid)
      sample_ch.valid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (16) @(posedge clk);
  endtask

  task automatic write_field(input logic [IDX_W-1:0] idx, input int unsigned bits);
    logic [HEAT_W-1:0] ones;
    logic [HEAT_W-1:0] v;
    ones = (40'd1 << bits) - 40'd1;
    case ($urandom_range(0, 3))
      0: v = '0;
      1: v = ones;
      default: v = HEAT_W'({$urandom, $urandom}) & ones;
    endcase
    // junk above the field must be dropped
    if ($urandom_range(0, 3) == 0)
      v = v | HEAT_W'({$urandom, $urandom} << bits);
    write_cfg(idx, v);
  endtask

  task automatic randomize_config();
    logic [HEAT_W:0]   lim;
    logic [HEAT_W-1:0] head;
    int unsigned       shift;
    write_field(REG_STALL_CURRENT, CUR_W);
    write_field(REG_WARNING_CURRENT, CUR_W);
    write_field(REG_MIN_TICK_DELTA, MIN_W);
    write_field(REG_STALL_PWM_LEVEL, PWM_W);
    write_field(REG_LIMP_PWM_LIMIT, PWM_W);
    write_field(REG_TICK_INTERVAL_MS, TICK_W);
    write_field(REG_COOLING_PER_MS, COOL_W);
    // keep the limit above the present heat so shutdown is saved for the end
    shift = $urandom_range(4, HEAT_W);
    head  = HEAT_W'({$urandom, $urandom});
    head  = head >> (HEAT_W - shift);
    lim   = {1'b0, sb.heat} + {1'b0, head} + 41'd1;
    if (lim[HEAT_W] || $urandom_range(0, 7) == 0)
      lim = {1'b0, HEAT_MAX};
    write_cfg(REG_THERMAL_LIMIT, lim[HEAT_W-1:0]);
    write_cfg(IDX_W'($urandom_range(8, (1 << IDX_W) - 1)), HEAT_W'({$urandom, $urandom}));
  endtask

  task automatic send_random(input int n, input bit steer);
    logic [CUR_W-1:0]          cur;
    logic signed [DELTA_W-1:0] delta;
    logic [PWM_W-1:0]          pwm;
    logic [HEAT_W:0]           next_heat;
    int                        d;
    repeat (n) begin
      cur   = CUR_W'($urandom);
      delta = DELTA_W'($urandom);
      pwm   = PWM_W'($urandom);
      case ($urandom_range(0, 9))
        0, 1, 2, 3: begin
          // stall-like: high duty, high current, wheel barely moving
          cur   = CUR_W'($urandom_range(sb.stall_cur, (1 << CUR_W) - 1));
          pwm   = PWM_W'($urandom_range(sb.stall_pwm, (1 << PWM_W) - 1));
          d     = int'(sb.min_delta) - int'($urandom_range(0, 64));
          delta = DELTA_W'(d);
        end
        4, 5: cur = CUR_W'($urandom_range(0, sb.stall_cur));
        default: ;
      endcase
      if (steer && cur > sb.stall_cur) begin
        next_heat = {1'b0, sb.heat} +
                    (HEAT_W+1)'(GAIN_W'(cur) * GAIN_W'(cur) * GAIN_W'(sb.tick_ms));
        if (next_heat >= {1'b0, sb.limit})
          cur = CUR_W'($urandom_range(0, sb.stall_cur));
      end
      send_sample(cur, delta, pwm);
    end
  endtask

  initial begin
    logic [HEAT_W-1:0] half_lim;
    idle_on  = 1'b1;
    hold_req = 1'b0;
    rst <= 1'b1;
    sample_ch.valid         <= 1'b0;
    sample_ch.motor_current <= '0;
    sample_ch.encoder_delta <= '0;
    sample_ch.duty_cmd      <= '0;
    cfg_ch.valid <= 1'b0;
    cfg_ch.index <= '0;
    cfg_ch.data  <= '0;
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // reset configuration: thresholds at and around their edges
    send_sample(12'd0, 16'sd0, 7'd0);
    send_sample(12'd1536, 16'sd4, 7'd40);
    send_sample(12'd1536, 16'sd5, 7'd40);
    send_sample(12'd1075, -16'sd1, 7'd39);
    send_sample(12'd1076, 16'sd0, 7'd100);
    send_sample(12'd1537, 16'sd100, 7'd101);
    send_sample(12'd1537, 16'sd100, 7'd127);
    send_sample(12'd0, 16'sd32767, 7'd127);
    send_sample(12'd0, -16'sd32768, 7'd0);
    send_sample(12'd1535, -16'sd32768, 7'd100);
    wait_drained();

    // register extremes; limp limit above the saturated duty
    write_cfg(REG_THERMAL_LIMIT, HEAT_MAX);
    write_cfg(REG_LIMP_PWM_LIMIT, HEAT_W'({PWM_W{1'b1}}));
    write_cfg(REG_STALL_PWM_LEVEL, '0);
    write_cfg(REG_MIN_TICK_DELTA, HEAT_W'({MIN_W{1'b1}}));
    write_cfg(REG_STALL_CURRENT, HEAT_W'({CUR_W{1'b1}}));
    write_cfg(REG_WARNING_CURRENT, '0);
    write_cfg(REG_TICK_INTERVAL_MS, HEAT_W'({TICK_W{1'b1}}));
    write_cfg(REG_COOLING_PER_MS, HEAT_W'({COOL_W{1'b1}}));
    send_sample(12'hFFF, -16'sd32768, 7'd127);
    send_sample(12'hFFF, 16'sd32767, 7'd0);
    send_sample(12'd0, 16'sd0, 7'd0);
    send_sample(12'hFFF, 16'sd0, 7'd100);
    wait_drained();

    // half limit: 2*heat equal to the limit is not yet limp, one more unit is
    write_cfg(REG_TICK_INTERVAL_MS, 40'd1);
    write_cfg(REG_STALL_CURRENT, '0);
    write_cfg(REG_WARNING_CURRENT, HEAT_W'({CUR_W{1'b1}}));
    write_cfg(REG_STALL_PWM_LEVEL, HEAT_W'({PWM_W{1'b1}}));
    write_cfg(REG_LIMP_PWM_LIMIT, 40'd20);
    write_cfg(REG_COOLING_PER_MS, '0);
    half_lim = (sb.heat + 40'd4095 * 40'd4095 + 40'd1) << 1;
    write_cfg(REG_THERMAL_LIMIT, half_lim);
    send_sample(12'hFFF, 16'sd0, 7'd50);
    send_sample(12'd1, 16'sd0, 7'd50);
    send_sample(12'd1, 16'sd0, 7'd50);
    wait_drained();

    // zero tick interval freezes the accumulator both ways
    write_cfg(REG_TICK_INTERVAL_MS, '0);
    write_cfg(REG_COOLING_PER_MS, HEAT_W'({COOL_W{1'b1}}));
    write_cfg(REG_MIN_TICK_DELTA, '0);
    write_cfg(IDX_W'(8), HEAT_W'({$urandom, $urandom}));
    write_cfg({IDX_W{1'b1}}, HEAT_W'({$urandom, $urandom}));
    send_sample(12'hFFF, 16'sd0, 7'd60);
    send_sample(12'd0, -16'sd1, 7'd60);
    wait_drained();

    for (int p = 0; p < 7; p++) begin
      idle_on = (p != 4);
      randomize_config();
      if (p == 2)
        hold_req = 1'b1;
      send_random(175, 1'b1);
      wait_drained();
    end

    // last part: no idling, zero limit trips at once, then shutdown must hold
    idle_on = 1'b0;
    write_cfg(REG_STALL_CURRENT, '0);
    write_cfg(REG_WARNING_CURRENT, '0);
    write_cfg(REG_STALL_PWM_LEVEL, 40'd40);
    write_cfg(REG_LIMP_PWM_LIMIT, 40'd20);
    write_cfg(REG_TICK_INTERVAL_MS, HEAT_W'({TICK_W{1'b1}}));
    write_cfg(REG_COOLING_PER_MS, '0);
    write_cfg(REG_THERMAL_LIMIT, '0);
    send_sample(12'd0, 16'sd0, 7'd50);
    // drive the accumulator into saturation while latched
    repeat (70) send_sample(12'hFFF, DELTA_W'($urandom), PWM_W'($urandom));
    wait_drained();
    write_cfg(REG_THERMAL_LIMIT, HEAT_MAX);
    write_cfg(REG_COOLING_PER_MS, HEAT_W'({COOL_W{1'b1}}));
    send_random(80, 1'b0);
    wait_drained();

    if (sb.errors == 0)
      $display("ALL CHECKS PASSED");
    else
      $display("CHECKS FAILED");
    $finish;
  end

endmodule

### filelist.f
rtl/core/mstp_pkg.sv
rtl/core/mstp_ifs.sv
rtl/core/motor_stall_i2t_protector.sv
dv/tb_motor_stall_i2t_protector.sv
